FILE: design/ropblit_pkg.sv
`default_nettype none

package ropblit_pkg;

    // surface size limit, larger sizes are clamped to it
    localparam logic [12:0] MAX_DIM = 13'd4096;

    // raster operation codes
    localparam logic [31:0] ROP_COPY  = 32'h00CC_0020;
    localparam logic [31:0] ROP_NCOPY = 32'h0033_0008;
    localparam logic [31:0] ROP_AND   = 32'h0088_00C6;
    localparam logic [31:0] ROP_OR    = 32'h00EE_0086;
    localparam logic [31:0] ROP_WHITE = 32'h00FF_0062;
    localparam logic [31:0] ROP_BLACK = 32'h0000_0042;

    localparam logic [23:0] COLOR_ONES = 24'hFF_FFFF;
    localparam logic [23:0] MONO_ONES  = 24'h00_0001;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_ROP_CODE   = 3'd0;
    localparam logic [2:0] REG_PIX_FMT    = 3'd1;
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd2;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd3;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd4;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd5;
    localparam logic [2:0] REG_MONO_ON    = 3'd6;
    localparam logic [2:0] REG_MONO_OFF   = 3'd7;

    // function codes
    localparam logic FUNC_BLIT = 1'b0;
    localparam logic FUNC_FILL = 1'b1;

    typedef struct packed {
        logic [31:0] rop_code;
        logic [1:0]  pixel_formats;
        logic [12:0] source_width;
        logic [12:0] source_height;
        logic [12:0] dest_width;
        logic [12:0] dest_height;
        logic [23:0] mono_on_color;
        logic [23:0] mono_off_color;
    } cfg_t;

    typedef struct packed {
        logic        func;
        logic [13:0] dst_x;
        logic [13:0] dst_y;
        logic [13:0] src_x;
        logic [13:0] src_y;
        logic [23:0] src_pixel;
        logic [23:0] dst_pixel;
        logic [23:0] fill_color;
        logic        final_pixel;
    } pix_req_t;

    typedef struct packed {
        logic        write_enable;
        logic [23:0] new_pixel;
        logic [25:0] dest_byte_addr;
        logic [7:0]  dest_bit_mask;
        logic        final_out;
    } pix_res_t;

    // clamp a surface size to the supported maximum
    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        logic [12:0] r;
        r = (v > MAX_DIM) ? MAX_DIM : v;
        return r;
    endfunction

    // raster operation on values whose all-ones pattern is given
    function automatic logic [23:0] apply_rop(input logic [31:0] code,
                                              input logic [23:0] d,
                                              input logic [23:0] s,
                                              input logic [23:0] ones);
        logic [23:0] r;
        case (code)
            ROP_COPY:  r = s;
            ROP_NCOPY: r = s ^ ones;
            ROP_AND:   r = s & d;
            ROP_OR:    r = s | d;
            ROP_WHITE: r = ones;
            ROP_BLACK: r = 24'd0;
            default:   r = d;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/raster_op_pixel_blit_unit.sv
// Raster-operation pixel unit of a 2-D blitter.
// Pixel requests enter on the s_axis stream, one pixel per request; the
// function (blit or fill) rides on tuser and the last pixel of a rectangle
// on tlast. Results leave on m_axis: write enable on tuser, new pixel,
// destination byte address and mono bit mask in tdata, tlast copied through.
// Surface sizes, pixel formats, mono colours and the raster operation are
// set through the APB port; change them only while no pixel is in flight.
// An accepted request passes one input register, then clipping, format
// conversion, raster operation and one row-pitch multiply feeding the result
// register. Throughput is one pixel per clock while results are taken.
// Both pipeline registers advance together when the receiver takes the
// result, so a stalled receiver holds the result steady and backs up into
// tready after the input register also fills.
// Reset clears both valid bits and loads the register defaults (copy
// operation, colour formats, 1x1 surfaces, white mono-on, black mono-off).
`default_nettype none

module raster_op_pixel_blit_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // pixel requests
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // dst_x[13:0], dst_y[27:14], src_x[41:28], src_y[55:42],
    // src_pixel[79:56], dst_pixel[103:80], fill_color[127:104]
    input  wire logic [127:0]  s_axis_tdata,
    // func[0]
    input  wire logic          s_axis_tuser,
    input  wire logic          s_axis_tlast,
    // pixel results
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // new_pixel[23:0], dest_byte_addr[49:24], dest_bit_mask[57:50], zero[63:58]
    output logic [63:0]        m_axis_tdata,
    // write_enable[0]
    output logic               m_axis_tuser,
    output logic               m_axis_tlast
);
    import ropblit_pkg::*;

    cfg_t     cfg;
    pix_req_t req_reg;
    pix_req_t req_next;
    pix_res_t res_next;
    pix_res_t res_reg;
    logic     req_vld_reg;
    logic     res_vld_reg;
    logic     res_free;
    logic     req_take;

    ropblit_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // unpack the request
    always_comb
    begin
        req_next.func        = s_axis_tuser;
        req_next.dst_x       = s_axis_tdata[13:0];
        req_next.dst_y       = s_axis_tdata[27:14];
        req_next.src_x       = s_axis_tdata[41:28];
        req_next.src_y       = s_axis_tdata[55:42];
        req_next.src_pixel   = s_axis_tdata[79:56];
        req_next.dst_pixel   = s_axis_tdata[103:80];
        req_next.fill_color  = s_axis_tdata[127:104];
        req_next.final_pixel = s_axis_tlast;
    end

    // pipeline flow control
    assign res_free      = !res_vld_reg || m_axis_tready;
    assign s_axis_tready = !req_vld_reg || res_free;
    assign req_take      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                req_vld_reg <= s_axis_tvalid;
            if (res_free)
                res_vld_reg <= req_vld_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (req_take)
            req_reg <= req_next;
    end

    ropblit_pixel_core u_core (
        .cfg (cfg),
        .req (req_reg),
        .res (res_next)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (res_free && req_vld_reg)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = res_vld_reg;
    assign m_axis_tuser  = res_reg.write_enable;
    assign m_axis_tlast  = res_reg.final_out;
    assign m_axis_tdata  = {6'd0, res_reg.dest_bit_mask, res_reg.dest_byte_addr,
                            res_reg.new_pixel};

    // a clipped pixel never carries payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
        else $error("clipped result with nonzero payload");

    // at most one mono bit selected
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(res_reg.dest_bit_mask))
        else $error("bit mask has more than one bit set");

    // a held request is not dropped while the result stage is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_vld_reg && !res_free) |=> req_vld_reg)
        else $error("pending request lost under stall");

    // input register only refills when its content moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_vld_reg && !res_free) |-> !s_axis_tready)
        else $error("request accepted over a pending one");

endmodule

`default_nettype wire

FILE: design/ropblit_cfg_regs.sv
`default_nettype none

module ropblit_cfg_regs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output ropblit_pkg::cfg_t      cfg
);
    import ropblit_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rop_code       <= ROP_COPY;
            cfg_reg.pixel_formats  <= 2'd0;
            cfg_reg.source_width   <= 13'd1;
            cfg_reg.source_height  <= 13'd1;
            cfg_reg.dest_width     <= 13'd1;
            cfg_reg.dest_height    <= 13'd1;
            cfg_reg.mono_on_color  <= COLOR_ONES;
            cfg_reg.mono_off_color <= 24'd0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ROP_CODE:   cfg_reg.rop_code       <= pwdata;
                REG_PIX_FMT:    cfg_reg.pixel_formats  <= pwdata[1:0];
                REG_SRC_WIDTH:  cfg_reg.source_width   <= pwdata[12:0];
                REG_SRC_HEIGHT: cfg_reg.source_height  <= pwdata[12:0];
                REG_DST_WIDTH:  cfg_reg.dest_width     <= pwdata[12:0];
                REG_DST_HEIGHT: cfg_reg.dest_height    <= pwdata[12:0];
                REG_MONO_ON:    cfg_reg.mono_on_color  <= pwdata[23:0];
                REG_MONO_OFF:   cfg_reg.mono_off_color <= pwdata[23:0];
                default:        cfg_reg.rop_code       <= cfg_reg.rop_code;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_ROP_CODE:   prdata = cfg_reg.rop_code;
            REG_PIX_FMT:    prdata = {30'd0, cfg_reg.pixel_formats};
            REG_SRC_WIDTH:  prdata = {19'd0, cfg_reg.source_width};
            REG_SRC_HEIGHT: prdata = {19'd0, cfg_reg.source_height};
            REG_DST_WIDTH:  prdata = {19'd0, cfg_reg.dest_width};
            REG_DST_HEIGHT: prdata = {19'd0, cfg_reg.dest_height};
            REG_MONO_ON:    prdata = {8'd0, cfg_reg.mono_on_color};
            REG_MONO_OFF:   prdata = {8'd0, cfg_reg.mono_off_color};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/ropblit_pixel_core.sv
`default_nettype none

module ropblit_pixel_core (
    input  wire ropblit_pkg::cfg_t     cfg,
    input  wire ropblit_pkg::pix_req_t req,
    output ropblit_pkg::pix_res_t      res
);
    import ropblit_pkg::*;

    logic [12:0] dw;
    logic [12:0] dh;
    logic [12:0] sw;
    logic [12:0] sh;
    logic        dst_in;
    logic        src_in;
    logic        ok;
    logic        src_mono;
    logic        dst_mono;
    logic        is_fill;
    logic [11:0] ux;
    logic [11:0] uy;
    logic [13:0] w_round;
    logic [12:0] row_mult;
    logic [24:0] prod;
    logic [24:0] col_sum;
    logic [25:0] addr;
    logic [7:0]  mask;
    logic        sbit;
    logic [23:0] scol;
    logic [23:0] rop_d;
    logic [23:0] rop_s;
    logic [23:0] rop_ones;
    logic [23:0] rop_out;
    logic [23:0] pix;

    assign src_mono = cfg.pixel_formats[0];
    assign dst_mono = cfg.pixel_formats[1];
    assign is_fill  = (req.func == FUNC_FILL);

    // clipping against the clamped surface sizes
    assign dw = clamp_dim(cfg.dest_width);
    assign dh = clamp_dim(cfg.dest_height);
    assign sw = clamp_dim(cfg.source_width);
    assign sh = clamp_dim(cfg.source_height);

    assign dst_in = !req.dst_x[13] && (req.dst_x[12:0] < dw) &&
                    !req.dst_y[13] && (req.dst_y[12:0] < dh);
    assign src_in = !req.src_x[13] && (req.src_x[12:0] < sw) &&
                    !req.src_y[13] && (req.src_y[12:0] < sh);
    assign ok     = dst_in && (is_fill || src_in);

    // coordinates are below 4096 once clipping passes
    assign ux = req.dst_x[11:0];
    assign uy = req.dst_y[11:0];

    // row pitch: 32-bit padded bytes for mono, pixels (x4 later) for colour
    assign w_round  = {1'b0, dw} + 14'd31;
    assign row_mult = dst_mono ? {2'b00, w_round[13:5], 2'b00} : dw;
    assign prod     = 25'(uy) * 25'(row_mult);
    assign col_sum  = prod + 25'(ux);

    always_comb
    begin
        if (dst_mono)
        begin
            addr = 26'(prod) + 26'(ux[11:3]);
            mask = 8'h80 >> ux[2:0];
        end
        else
        begin
            addr = {col_sum[23:0], 2'b00};
            mask = 8'd0;
        end
    end

    // source conversion and raster operation
    assign sbit = src_mono ? req.src_pixel[0] : (req.src_pixel == cfg.mono_on_color);
    assign scol = src_mono ? (req.src_pixel[0] ? cfg.mono_on_color : cfg.mono_off_color)
                           : req.src_pixel;

    assign rop_d    = dst_mono ? {23'd0, req.dst_pixel[0]} : req.dst_pixel;
    assign rop_s    = dst_mono ? {23'd0, sbit} : scol;
    assign rop_ones = dst_mono ? MONO_ONES : COLOR_ONES;
    assign rop_out  = apply_rop(cfg.rop_code, rop_d, rop_s, rop_ones);

    always_comb
    begin
        if (is_fill)
            pix = dst_mono ? {23'd0, (req.fill_color == cfg.mono_on_color)}
                           : req.fill_color;
        else
            pix = dst_mono ? {23'd0, rop_out[0]} : rop_out;
    end

    // clipped pixels give an all-zero payload
    assign res.write_enable   = ok;
    assign res.new_pixel      = ok ? pix  : 24'd0;
    assign res.dest_byte_addr = ok ? addr : 26'd0;
    assign res.dest_bit_mask  = ok ? mask : 8'd0;
    assign res.final_out      = req.final_pixel;

endmodule

`default_nettype wire
